>>> design/bounded_deque_search_delete_unit_assert.svh
`ifndef BOUNDED_DEQUE_SEARCH_DELETE_UNIT_ASSERT_SVH
`define BOUNDED_DEQUE_SEARCH_DELETE_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define BDSD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bdsd assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define BDSD_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bdsd assertion failed");

`endif

>>> design/bdsd_pkg.sv
package bdsd_pkg;

   localparam int DEPTH  = 16;
   localparam int WORD_W = 32;
   localparam int DATA_W = 32;
   localparam int FUNC_W = 4;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   typedef enum logic [FUNC_W-1:0] {
      FN_PUSH_TAIL = 4'd0,
      FN_PUSH_HEAD = 4'd1,
      FN_POP_TAIL  = 4'd2,
      FN_POP_HEAD  = 4'd3,
      FN_PEEK_TAIL = 4'd4,
      FN_PEEK_HEAD = 4'd5,
      FN_FIND      = 4'd6,
      FN_DEL_TAIL  = 4'd7,
      FN_DEL_HEAD  = 4'd8
   } func_type;

   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_EMPTY     = 2'd1,
      STS_FULL      = 2'd2,
      STS_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_FETCH,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_DONE
   } seq_state_type;

   typedef struct packed {
      logic              rd_en;
      logic              wr_en;
      logic [IDX_W-1:0]  addr;
      logic [WORD_W-1:0] wr_data;
   } mem_cmd_type;

   typedef struct packed {
      logic [DATA_W-1:0] data;
      status_type        status;
      logic [CNT_W-1:0]  count;
   } result_type;

   // Physical slot of a logical position in the circular store.
   function automatic logic [IDX_W-1:0] bdsd_wrap(input logic [IDX_W-1:0] head,
                                                  input logic [IDX_W-1:0] pos);
      logic [IDX_W:0] sum;
      sum = {1'b0, head} + {1'b0, pos};
      if (sum >= (IDX_W + 1)'(DEPTH)) begin
         sum = sum - (IDX_W + 1)'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

>>> design/bdsd_req_if.sv
interface bdsd_req_if import bdsd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [DATA_W-1:0] data;

   modport source (output valid, output func, output data, input ready);
   modport sink (input valid, input func, input data, output ready);
endinterface

>>> design/bdsd_rsp_if.sv
interface bdsd_rsp_if import bdsd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_out;
   logic [1:0]        status;
   logic              is_empty;
   logic [CNT_W-1:0]  count;

   modport source (output valid, output data_out, output status, output is_empty,
                   output count, input ready);
   modport sink (input valid, input data_out, input status, input is_empty,
                 input count, output ready);
endinterface

>>> design/bdsd_seq.sv
module bdsd_seq import bdsd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [FUNC_W-1:0] req_func,
   input  logic [DATA_W-1:0] req_data,
   output logic              req_ready,
   input  logic              out_free,
   input  logic [WORD_W-1:0] rdata,
   output mem_cmd_type       mem_cmd,
   output logic              done,
   output result_type        result
);

   seq_state_type     state_ff, state_in;
   func_type          func_ff, func_in;
   logic [WORD_W-1:0] key_ff, key_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  step_ff, step_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic [WORD_W-1:0] res_data_ff, res_data_in;
   status_type        res_status_ff, res_status_in;

   logic              accept;
   logic              from_tail;
   logic              is_full;
   logic              is_empty;
   logic              match;
   logic              last_step;
   logic              at_tail;
   logic              shift_end;
   logic [IDX_W-1:0]  head_dec;
   logic [IDX_W-1:0]  pos_sel;
   logic [IDX_W-1:0]  phys;

   assign accept    = req_valid && req_ready;
   assign from_tail = (func_ff != FN_DEL_HEAD);
   assign is_full   = (count_ff == CNT_W'(DEPTH));
   assign is_empty  = (count_ff == '0);
   assign match     = (rdata == key_ff);
   assign last_step = ((CNT_W'(step_ff) + CNT_W'(1)) == count_ff);
   assign at_tail   = ((CNT_W'(pos_ff) + CNT_W'(1)) == count_ff);
   assign shift_end = ((CNT_W'(pos_ff) + CNT_W'(2)) == count_ff);
   assign head_dec  = (head_ff == '0) ? IDX_W'(DEPTH - 1) : head_ff - IDX_W'(1);

   // Logical position fed to the shared slot adder.
   always_comb begin
      pos_sel = pos_ff;
      case (state_ff)
         S_EXEC: begin
            case (func_ff)
               FN_PUSH_TAIL:             pos_sel = IDX_W'(count_ff);
               FN_POP_TAIL, FN_PEEK_TAIL: pos_sel = IDX_W'(count_ff - CNT_W'(1));
               default:                  pos_sel = '0;
            endcase
         end
         S_FETCH:    pos_sel = IDX_W'(1);
         S_SCAN_RD: begin
            if (from_tail) begin
               pos_sel = IDX_W'(count_ff - CNT_W'(1) - CNT_W'(step_ff));
            end else begin
               pos_sel = step_ff;
            end
         end
         S_SHIFT_RD: pos_sel = pos_ff + IDX_W'(1);
         default:    pos_sel = pos_ff;
      endcase
   end

   assign phys = bdsd_wrap(head_ff, pos_sel);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_EXEC;
         end
         S_EXEC: begin
            case (func_ff)
               FN_POP_TAIL, FN_POP_HEAD, FN_PEEK_TAIL, FN_PEEK_HEAD: begin
                  state_in = is_empty ? S_DONE : S_FETCH;
               end
               FN_FIND, FN_DEL_TAIL, FN_DEL_HEAD: begin
                  state_in = is_empty ? S_DONE : S_SCAN_RD;
               end
               default: state_in = S_DONE;
            endcase
         end
         S_FETCH:   state_in = S_DONE;
         S_SCAN_RD: state_in = S_SCAN_CMP;
         S_SCAN_CMP: begin
            if (match) begin
               if (func_ff == FN_FIND || at_tail) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_SHIFT_RD;
               end
            end else if (last_step) begin
               state_in = S_DONE;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_SHIFT_RD: state_in = S_SHIFT_WR;
         S_SHIFT_WR: state_in = shift_end ? S_DONE : S_SHIFT_RD;
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs, memory commands and datapath updates.
   always_comb begin
      func_in       = func_ff;
      key_in        = key_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      pos_in        = pos_ff;
      res_data_in   = res_data_ff;
      res_status_in = res_status_ff;
      mem_cmd       = '0;
      req_ready     = (state_ff == S_IDLE);
      done          = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               func_in = func_type'(req_func);
               key_in  = WORD_W'(req_data);
               step_in = '0;
            end
         end
         S_EXEC: begin
            res_data_in   = '0;
            res_status_in = STS_OK;
            case (func_ff)
               FN_PUSH_TAIL, FN_PUSH_HEAD: begin
                  if (is_full) begin
                     res_status_in = STS_FULL;
                  end else begin
                     mem_cmd.wr_en   = 1'b1;
                     mem_cmd.wr_data = key_ff;
                     count_in        = count_ff + CNT_W'(1);
                     if (func_ff == FN_PUSH_HEAD) begin
                        mem_cmd.addr = head_dec;
                        head_in      = head_dec;
                     end else begin
                        mem_cmd.addr = phys;
                     end
                  end
               end
               FN_POP_TAIL, FN_POP_HEAD, FN_PEEK_TAIL, FN_PEEK_HEAD: begin
                  if (is_empty) begin
                     res_status_in = STS_EMPTY;
                  end else begin
                     mem_cmd.rd_en = 1'b1;
                     mem_cmd.addr  = phys;
                  end
               end
               FN_FIND, FN_DEL_TAIL, FN_DEL_HEAD: begin
                  if (is_empty) res_status_in = STS_NOT_FOUND;
               end
               default: res_status_in = STS_OK;
            endcase
         end
         S_FETCH: begin
            res_data_in = rdata;
            if (func_ff == FN_POP_TAIL) begin
               count_in = count_ff - CNT_W'(1);
            end else if (func_ff == FN_POP_HEAD) begin
               count_in = count_ff - CNT_W'(1);
               head_in  = phys;
            end
         end
         S_SCAN_RD: begin
            mem_cmd.rd_en = 1'b1;
            mem_cmd.addr  = phys;
            pos_in        = pos_sel;
         end
         S_SCAN_CMP: begin
            if (match) begin
               res_data_in = key_ff;
               if (func_ff != FN_FIND && at_tail) begin
                  count_in = count_ff - CNT_W'(1);
               end
            end else begin
               step_in = step_ff + IDX_W'(1);
               if (last_step) res_status_in = STS_NOT_FOUND;
            end
         end
         S_SHIFT_RD: begin
            mem_cmd.rd_en = 1'b1;
            mem_cmd.addr  = phys;
         end
         S_SHIFT_WR: begin
            mem_cmd.wr_en   = 1'b1;
            mem_cmd.addr    = phys;
            mem_cmd.wr_data = rdata;
            pos_in          = pos_ff + IDX_W'(1);
            if (shift_end) count_in = count_ff - CNT_W'(1);
         end
         S_DONE: begin
            done = out_free;
         end
         default: begin
            done = 1'b0;
         end
      endcase
   end

   assign result.data   = DATA_W'(res_data_ff);
   assign result.status = res_status_ff;
   assign result.count  = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      key_ff        <= key_in;
      step_ff       <= step_in;
      pos_ff        <= pos_in;
      res_data_ff   <= res_data_in;
      res_status_ff <= res_status_in;
   end

endmodule

>>> design/bounded_deque_search_delete_unit.sv
// Channel   Modport  Beat contents                            Handshake
// req_bus   sink     func, data                               valid/ready
// rsp_bus   source   data_out, status, is_empty, count        valid/ready
//
// One request beat is worked on at a time; the request side is ready only while the sequencer
// is idle. A push goes through execute and done before its result is loaded, a pop or peek also
// through fetch. Find and delete compare one entry at a time through the single store port; a
// delete then closes the gap, reading and writing each later entry. The next request can be
// taken in the cycle after the result is loaded. Reset is synchronous and empties the queue;
// the store needs no clearing. A stalled result holds the sequencer in its final state only.

`include "bounded_deque_search_delete_unit_assert.svh"

module bounded_deque_search_delete_unit import bdsd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   bdsd_req_if.sink  req_bus,
   bdsd_rsp_if.source rsp_bus
);

   // The queue lives in a circular store: the sequencer keeps the head slot and
   // the entry count, so pushes and pops at either end need no data movement.
   logic [WORD_W-1:0] store [DEPTH];
   logic [WORD_W-1:0] rdata_ff;

   mem_cmd_type       mem_cmd;
   result_type        result;
   logic              done;
   logic              out_free;
   logic              req_ready;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff;
   status_type        rsp_status_ff;
   logic              rsp_empty_ff;
   logic [CNT_W-1:0]  rsp_count_ff;

   // The output register frees up in the same cycle that its beat is taken.
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   bdsd_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_func  (req_bus.func),
      .req_data  (req_bus.data),
      .req_ready (req_ready),
      .out_free  (out_free),
      .rdata     (rdata_ff),
      .mem_cmd   (mem_cmd),
      .done      (done),
      .result    (result)
   );

   assign req_bus.ready = req_ready;

   // Single-port store with a registered read; the sequencer never issues a read
   // and a write in the same cycle.
   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         store[mem_cmd.addr] <= mem_cmd.wr_data;
      end
      if (mem_cmd.rd_en) begin
         rdata_ff <= store[mem_cmd.addr];
      end
   end

   // Result beat register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_data_ff   <= result.data;
         rsp_status_ff <= result.status;
         rsp_empty_ff  <= (result.count == '0);
         rsp_count_ff  <= result.count;
      end
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.data_out = rsp_data_ff;
   assign rsp_bus.status   = rsp_status_ff;
   assign rsp_bus.is_empty = rsp_empty_ff;
   assign rsp_bus.count    = rsp_count_ff;

   // A dropped push is only ever reported for a full queue.
   `BDSD_ASSERT_IMP(a_full_count, clock, reset, rsp_valid_ff && rsp_status_ff == STS_FULL, rsp_count_ff == CNT_W'(DEPTH))
   // An empty report always comes with an empty queue.
   `BDSD_ASSERT_IMP(a_empty_flag, clock, reset, rsp_valid_ff && rsp_status_ff == STS_EMPTY, rsp_empty_ff && rsp_count_ff == '0)
   // Once a request beat is taken, the sequencer is busy in the next cycle.
   `BDSD_ASSERT_NXT(a_busy_after_accept, clock, reset, req_bus.valid && req_ready, !req_ready)
   // The single store port carries a read or a write, never both.
   `BDSD_ASSERT_IMP(a_one_port_op, clock, reset, mem_cmd.rd_en, !mem_cmd.wr_en)

endmodule

>>> tb/bounded_deque_search_delete_unit_test.sv
module bounded_deque_search_delete_unit_test;
   import bdsd_pkg::*;

   // Operation codes nine to fifteen do nothing but still return a reply.
   localparam logic [FUNC_W-1:0] FN_SPARE_LO = 4'd9;
   localparam logic [FUNC_W-1:0] FN_SPARE_HI = 4'd15;

   // The slowest request is a delete that scans all sixteen entries and then
   // compacts those behind its hit, so the settle wait covers anything in flight.
   localparam int SETTLE_CYCLES = 100;
   localparam int CYCLE_LIMIT   = 400000;

   typedef struct {
      logic [DATA_W-1:0] data_out;
      status_type        status;
      logic              is_empty;
      logic [CNT_W-1:0]  count;
   } reply_type;

   logic clock;
   logic reset;

   bdsd_req_if req_bus ();
   bdsd_rsp_if rsp_bus ();

   bounded_deque_search_delete_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Replies that the deque owes us, oldest first, and our own copy of the
   // deque contents from head (index 0) to tail.
   reply_type         awaited_replies[$];
   logic [DATA_W-1:0] model_words[$];

   // Idle rates in percent for the request and reply sides, and the length of
   // a forced reply stall in cycles.
   int send_idle_pct = 16;
   int rsp_idle_pct  = 16;
   int hold_left     = 0;

   int mismatch_count  = 0;
   int beats_sent      = 0;
   int replies_checked = 0;
   int full_drops      = 0;
   int empty_hits      = 0;
   int key_hits        = 0;
   int peak_fill       = 0;
   int cycle_count     = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one accepted request to the local deque and returns the reply it
   // must produce. Searches from the tail for find and delete-nearest-tail,
   // from the head for delete-nearest-head; a delete closes the gap in order.
   function automatic reply_type deque_apply(input logic [FUNC_W-1:0] func,
                                             input logic [DATA_W-1:0] key);
      reply_type r;
      int        n;
      int        k;
      int        hit;
      r.data_out = '0;
      r.status   = STS_OK;
      n = model_words.size();
      case (func)
         FN_PUSH_TAIL, FN_PUSH_HEAD: begin
            if (n >= DEPTH) begin
               r.status = STS_FULL;
               full_drops++;
            end else if (func == FN_PUSH_TAIL) begin
               model_words.push_back(key);
            end else begin
               model_words.push_front(key);
            end
         end
         FN_POP_TAIL, FN_POP_HEAD, FN_PEEK_TAIL, FN_PEEK_HEAD: begin
            if (n == 0) begin
               r.status = STS_EMPTY;
               empty_hits++;
            end else begin
               case (func)
                  FN_POP_TAIL:  r.data_out = model_words.pop_back();
                  FN_POP_HEAD:  r.data_out = model_words.pop_front();
                  FN_PEEK_TAIL: r.data_out = model_words[n-1];
                  default:      r.data_out = model_words[0];
               endcase
            end
         end
         FN_FIND, FN_DEL_TAIL, FN_DEL_HEAD: begin
            hit = -1;
            if (func == FN_DEL_HEAD) begin
               for (k = 0; k < n; k++) begin
                  if (hit < 0 && model_words[k] == key) hit = k;
               end
            end else begin
               for (k = n - 1; k >= 0; k--) begin
                  if (hit < 0 && model_words[k] == key) hit = k;
               end
            end
            if (hit < 0) begin
               r.status = STS_NOT_FOUND;
            end else begin
               r.data_out = key;
               key_hits++;
               if (func != FN_FIND) model_words.delete(hit);
            end
         end
         default: begin
         end
      endcase
      r.count    = CNT_W'(model_words.size());
      r.is_empty = (model_words.size() == 0);
      if (model_words.size() > peak_fill) peak_fill = model_words.size();
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      mismatch_count++;
      $display("mismatch in %s: got %0h, expected %0h (reply %0d, cycle %0d)",
               what, got, want, replies_checked, cycle_count);
   endtask

   // Offers one request beat from the falling edge and holds it until the
   // deque takes it. The beat may be preceded by a random idle gap; when two
   // beats follow back to back, valid simply stays high.
   task automatic send_beat(input logic [FUNC_W-1:0] func,
                            input logic [DATA_W-1:0] key);
      int gap;
      @(negedge clock);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         gap = $urandom_range(1, 6);
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.func  = func;
      req_bus.data  = key;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      awaited_replies.push_back(deque_apply(func, key));
      beats_sent++;
   endtask

   // Drops valid and waits until every reply owed has been checked.
   task automatic pause_for_replies();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (awaited_replies.size() != 0) @(posedge clock);
   endtask

   // Data words lean on a small set of values so that duplicates are common,
   // with full-range words and single-bit patterns mixed in.
   function automatic logic [DATA_W-1:0] pick_word();
      logic [DATA_W-1:0] word;
      case ($urandom_range(0, 3))
         0, 1: word = DATA_W'($urandom_range(0, 7));
         2: word = $urandom;
         default: begin
            word = DATA_W'(1) << $urandom_range(0, DATA_W - 1);
            if ($urandom_range(0, 1) == 1) word = ~word;
         end
      endcase
      return word;
   endfunction

   // Search keys mostly hit something the deque holds right now.
   function automatic logic [DATA_W-1:0] pick_search_key();
      if (model_words.size() != 0 && $urandom_range(0, 3) != 0) begin
         return model_words[$urandom_range(0, model_words.size() - 1)];
      end
      return pick_word();
   endfunction

   // One random request. push_pct steers the fill level: high values drive
   // the deque to full, low values drain it through pops and deletes.
   task automatic random_item(input int push_pct);
      logic [FUNC_W-1:0] func;
      logic [DATA_W-1:0] key;
      int                roll;
      roll = $urandom_range(0, 99);
      if (roll < push_pct) begin
         func = ($urandom_range(0, 1) == 1) ? FN_PUSH_HEAD : FN_PUSH_TAIL;
         key  = pick_word();
      end else if (roll < push_pct + 25) begin
         case ($urandom_range(0, 3))
            0:       func = FN_POP_TAIL;
            1:       func = FN_POP_HEAD;
            2:       func = FN_PEEK_TAIL;
            default: func = FN_PEEK_HEAD;
         endcase
         key = pick_word();
      end else if (roll < 97) begin
         case ($urandom_range(0, 2))
            0:       func = FN_FIND;
            1:       func = FN_DEL_TAIL;
            default: func = FN_DEL_HEAD;
         endcase
         key = pick_search_key();
      end else begin
         func = FUNC_W'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
         key  = $urandom;
      end
      send_beat(func, key);
   endtask

   // Every take and search operation on an empty deque, with all-zero, all-one
   // and mixed data words.
   task automatic test_empty_queue();
      send_beat(FN_POP_TAIL, '0);
      send_beat(FN_POP_HEAD, '1);
      send_beat(FN_PEEK_TAIL, '0);
      send_beat(FN_PEEK_HEAD, '1);
      send_beat(FN_FIND, '0);
      send_beat(FN_DEL_TAIL, '1);
      send_beat(FN_DEL_HEAD, 32'h5A5A_A5A5);
   endtask

   // Fills the deque from both ends with four repeating words, then pushes
   // once more so that the push is dropped as full.
   task automatic test_fill_and_overflow();
      logic [DATA_W-1:0] pattern[4];
      int                k;
      pattern = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0001, 32'h7FFF_FFFE};
      for (k = 0; k < DEPTH; k++) begin
         send_beat((k % 2 == 1) ? FN_PUSH_HEAD : FN_PUSH_TAIL, pattern[k % 4]);
      end
      send_beat(FN_PUSH_TAIL, 32'h1234_5678);
   endtask

   // On the full deque, each word sits there four times, so each delete must
   // find the copy at its own end. The dropped word must not be found.
   task automatic test_search_and_delete();
      send_beat(FN_DEL_TAIL, 32'h0000_0000);
      send_beat(FN_DEL_HEAD, 32'hFFFF_FFFF);
      send_beat(FN_FIND, 32'h8000_0001);
      send_beat(FN_FIND, 32'h1234_5678);
      send_beat(FN_SPARE_HI, '1);
   endtask

   // Random traffic in three phases: filling, balanced and draining.
   task automatic test_random_traffic();
      repeat (150) random_item(70);
      repeat (150) random_item(45);
      repeat (150) random_item(25);
   endtask

   // Both sides run flat out: no request gaps and no reply stalls.
   task automatic test_no_idle_stretch();
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      repeat (150) random_item(45);
      send_idle_pct = 16;
      rsp_idle_pct  = 16;
   endtask

   // The reply side stalls for a long stretch while requests keep coming, so
   // the output register fills and the request side must stop taking beats.
   task automatic test_output_backpressure();
      hold_left = 400;
      repeat (30) random_item(60);
   endtask

   // The request side goes quiet until every reply is back, then resumes.
   task automatic test_input_pause();
      repeat (20) random_item(50);
      pause_for_replies();
      repeat (20) random_item(50);
   endtask

   // Reply side: ready changes only on falling edges. A forced hold counts
   // down here; otherwise ready drops at the current idle rate.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_bus.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready = ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   // Every reply beat is matched against the oldest awaited reply, field by
   // field. Values are sampled at the rising edge, before the deque updates.
   always @(posedge clock) begin : reply_checker
      reply_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (awaited_replies.size() == 0) begin
            report_mismatch("reply with none awaited", rsp_bus.data_out, '0);
         end else begin
            want = awaited_replies.pop_front();
            replies_checked++;
            if (rsp_bus.data_out !== want.data_out) begin
               report_mismatch("data_out", rsp_bus.data_out, want.data_out);
            end
            if (rsp_bus.status !== want.status) begin
               report_mismatch("status", DATA_W'(rsp_bus.status), DATA_W'(want.status));
            end
            if (rsp_bus.is_empty !== want.is_empty) begin
               report_mismatch("is_empty", DATA_W'(rsp_bus.is_empty),
                               DATA_W'(want.is_empty));
            end
            if (rsp_bus.count !== want.count) begin
               report_mismatch("count", DATA_W'(rsp_bus.count), DATA_W'(want.count));
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d replies outstanding",
                  cycle_count, awaited_replies.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.func  = '0;
      req_bus.data  = '0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      test_empty_queue();
      test_fill_and_overflow();
      test_search_and_delete();
      test_random_traffic();
      test_no_idle_stretch();
      test_output_backpressure();
      test_input_pause();

      pause_for_replies();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("deque run: %0d request beats, %0d replies checked, %0d mismatches",
               beats_sent, replies_checked, mismatch_count);
      $display("seen: %0d full drops, %0d empty takes, %0d key hits, peak fill %0d",
               full_drops, empty_hits, key_hits, peak_fill);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
